// ===== sv/ipv6tf_pkg.sv =====
`timescale 1ns / 1ps
// Shared types and constants for the IPv6 canonical text formatter.
// Used by the zero-run scanner and by the top level; depends on nothing.
package ipv6tf_pkg;

    // Number of 16-bit groups in one address.
    localparam int GROUP_COUNT = 8;

    // ASCII code of the group separator.
    localparam logic [6:0] C_ASCII_COLON = 7'h3A;

    // Lowercase hexadecimal digit characters, indexed by nibble value.
    localparam logic [6:0] C_HEX_CHARS [16] = '{
        7'h30, 7'h31, 7'h32, 7'h33, 7'h34, 7'h35, 7'h36, 7'h37,
        7'h38, 7'h39, 7'h61, 7'h62, 7'h63, 7'h64, 7'h65, 7'h66
    };

    // Result of the zero-run scan, handed from the scanner to the sequencer.
    typedef struct packed {
        logic       done;       // last scan step is taken at this edge
        logic [2:0] run_first;  // first group of the longest zero run
        logic [3:0] run_len;    // length of that run in groups, 0 to 8
    } t_run_info;

endpackage

// ===== sv/ipv6_canonical_text_formatter_unit.sv =====
`timescale 1ns / 1ps
// Top level of the IPv6 canonical text formatter: address register and
// character sequencer. Depends on ipv6tf_pkg and ipv6tf_run_scan.
//
// Usage:
//   An address transaction is taken at a rising edge where start is high and
//   busy is low; i_addr_high carries bytes 0..7 and i_addr_low bytes 8..15.
//   Characters leave one at a time on o_text_char, each shown for
//   exactly one cycle with o_strobe high; o_last_char marks the final one.
//   The receiver has no way to stall this stream and must take every strobe.
// Timing:
//   After the accept edge, the scanner steps through the zero flags of the groups.
//   The address register then shifts out one nibble per cycle outside the decision
//   states, including nibbles that print nothing. Each printed group starts with a
//   decision state that also puts out its separator; an elided run has one that puts
//   out the first colon of "::" and a state for the second. busy stays high throughout;
//   the final character shows in the first cycle with busy low, and the next address
//   can be taken from that cycle on, but not while busy is high.
// Reset:
//   Synchronous, active low; the block returns to idle, drops busy and any
//   strobe, and a transaction in progress is abandoned.
module ipv6_canonical_text_formatter_unit (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        start,
    output logic        busy,
    input  logic [63:0] i_addr_high,
    input  logic [63:0] i_addr_low,
    output logic        o_strobe,
    output logic [6:0]  o_text_char,
    output logic        o_last_char
);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_SCAN = 3'd1;
    localparam logic [2:0] ST_GRP  = 3'd2;
    localparam logic [2:0] ST_NIB  = 3'd3;
    localparam logic [2:0] ST_SKIP = 3'd4;
    localparam logic [2:0] ST_COL2 = 3'd5;

    logic [2:0]   r_state;
    logic [2:0]   n_state;
    logic [127:0] r_addr;
    logic [127:0] n_addr;
    logic [2:0]   r_grp;
    logic [2:0]   n_grp;
    logic [1:0]   r_nib;
    logic [1:0]   n_nib;
    logic         r_seen;
    logic         n_seen;
    logic         r_strobe;
    logic         n_strobe;
    logic [6:0]   r_char;
    logic [6:0]   n_char;
    logic         r_last;
    logic         n_last;

    logic                  load;
    logic [7:0]            zero_flags;
    ipv6tf_pkg::t_run_info run_info;
    logic                  elide;
    logic [3:0]            after;
    logic [3:0]            grp_ext;
    logic                  in_run;
    logic [3:0]            nib_val;
    logic                  show;

    assign load = start && (r_state == ST_IDLE);

    // Zero flag per group, group 0 in the top bit.
    always_comb begin
        for (int k = 0; k < 4; k++) begin
            zero_flags[7 - k] = (i_addr_high[63 - 16 * k -: 16] == 16'd0);
            zero_flags[3 - k] = (i_addr_low[63 - 16 * k -: 16] == 16'd0);
        end
    end

    ipv6tf_run_scan u_run_scan (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_load  (load),
        .i_zero  (zero_flags),
        .o_info  (run_info)
    );

    // Position of the current group relative to the elided run.
    assign elide   = (run_info.run_len >= 4'd2);
    assign after   = {1'b0, run_info.run_first} + run_info.run_len;
    assign grp_ext = {1'b0, r_grp};
    assign in_run  = elide && (grp_ext >= {1'b0, run_info.run_first}) && (grp_ext < after);
    assign nib_val = r_addr[127:124];
    assign show    = (nib_val != 4'd0) || r_seen || (r_nib == 2'd3);

    // Character sequencer.
    always_comb begin
        n_state  = r_state;
        n_addr   = r_addr;
        n_grp    = r_grp;
        n_nib    = r_nib;
        n_seen   = r_seen;
        n_strobe = 1'b0;
        n_char   = r_char;
        n_last   = 1'b0;
        case (r_state)
            ST_IDLE: begin
                if (start) begin
                    n_addr  = {i_addr_high, i_addr_low};
                    n_state = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (run_info.done) begin
                    n_grp   = 3'd0;
                    n_nib   = 2'd0;
                    n_seen  = 1'b0;
                    n_state = ST_GRP;
                end
            end
            ST_GRP: begin
                if (in_run) begin
                    // First colon of the elision; the run's nibbles are skipped.
                    n_strobe = 1'b1;
                    n_char   = ipv6tf_pkg::C_ASCII_COLON;
                    n_state  = ST_SKIP;
                end else begin
                    if ((r_grp != 3'd0) && !(elide && (grp_ext == after))) begin
                        n_strobe = 1'b1;
                        n_char   = ipv6tf_pkg::C_ASCII_COLON;
                    end
                    n_state = ST_NIB;
                end
            end
            ST_NIB: begin
                if (show) begin
                    n_strobe = 1'b1;
                    n_char   = ipv6tf_pkg::C_HEX_CHARS[nib_val];
                    n_last   = (r_nib == 2'd3) && (r_grp == 3'd7);
                    n_seen   = 1'b1;
                end
                n_addr = {r_addr[123:0], 4'd0};
                n_nib  = r_nib + 2'd1;
                if (r_nib == 2'd3) begin
                    n_seen  = 1'b0;
                    n_grp   = r_grp + 3'd1;
                    n_state = (r_grp == 3'd7) ? ST_IDLE : ST_GRP;
                end
            end
            ST_SKIP: begin
                n_addr = {r_addr[123:0], 4'd0};
                n_nib  = r_nib + 2'd1;
                if (r_nib == 2'd3) begin
                    n_grp = r_grp + 3'd1;
                    if ((grp_ext + 4'd1) == after) begin
                        n_state = ST_COL2;
                    end
                end
            end
            ST_COL2: begin
                // Second colon of the elision; final when the run reaches group 7.
                n_strobe = 1'b1;
                n_char   = ipv6tf_pkg::C_ASCII_COLON;
                n_last   = (after == 4'd8);
                n_state  = (after == 4'd8) ? ST_IDLE : ST_GRP;
            end
            default: begin
                n_state = ST_IDLE;
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_grp    <= 3'd0;
            r_nib    <= 2'd0;
            r_seen   <= 1'b0;
            r_strobe <= 1'b0;
        end else begin
            r_state  <= n_state;
            r_grp    <= n_grp;
            r_nib    <= n_nib;
            r_seen   <= n_seen;
            r_strobe <= n_strobe;
        end
    end

    // Payload registers.
    always_ff @(posedge i_clk) begin
        r_addr <= n_addr;
        r_char <= n_char;
        r_last <= n_last;
    end

    assign busy        = (r_state != ST_IDLE);
    assign o_strobe    = r_strobe;
    assign o_text_char = r_char;
    assign o_last_char = r_last;

endmodule

// ===== sv/ipv6tf_run_scan.sv =====
`timescale 1ns / 1ps
// Serial scan for the longest run of all-zero groups, one group per cycle.
// Depends on ipv6tf_pkg for the t_run_info result type.
module ipv6tf_run_scan (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_load,
    input  logic [7:0]            i_zero,
    output ipv6tf_pkg::t_run_info o_info
);

    logic [7:0] r_zero;
    logic [7:0] n_zero;
    logic [2:0] r_cnt;
    logic [2:0] n_cnt;
    logic [3:0] r_run;
    logic [3:0] n_run;
    logic [2:0] r_bs;
    logic [2:0] n_bs;
    logic [3:0] r_bl;
    logic [3:0] n_bl;
    logic       r_active;
    logic       n_active;
    logic [3:0] run_inc;

    assign run_inc = r_run + 4'd1;

    // One step of the run search per cycle; group 0 sits in the top flag bit.
    always_comb begin
        n_zero   = r_zero;
        n_cnt    = r_cnt;
        n_run    = r_run;
        n_bs     = r_bs;
        n_bl     = r_bl;
        n_active = r_active;
        if (i_load) begin
            n_zero   = i_zero;
            n_cnt    = 3'd0;
            n_run    = 4'd0;
            n_bs     = 3'd0;
            n_bl     = 4'd0;
            n_active = 1'b1;
        end else if (r_active) begin
            n_zero = {r_zero[6:0], 1'b0};
            n_cnt  = r_cnt + 3'd1;
            if (r_zero[7]) begin
                n_run = run_inc;
                // A strictly longer run replaces the best, so the first wins a tie.
                if (run_inc > r_bl) begin
                    n_bl = run_inc;
                    n_bs = r_cnt - r_run[2:0];
                end
            end else begin
                n_run = 4'd0;
            end
            if (r_cnt == 3'd7) begin
                n_active = 1'b0;
            end
        end
    end

    // All scan state is control state and is cleared by reset.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zero   <= 8'd0;
            r_cnt    <= 3'd0;
            r_run    <= 4'd0;
            r_bs     <= 3'd0;
            r_bl     <= 4'd0;
            r_active <= 1'b0;
        end else begin
            r_zero   <= n_zero;
            r_cnt    <= n_cnt;
            r_run    <= n_run;
            r_bs     <= n_bs;
            r_bl     <= n_bl;
            r_active <= n_active;
        end
    end

    assign o_info.done      = r_active && (r_cnt == 3'd7);
    assign o_info.run_first = r_bs;
    assign o_info.run_len   = r_bl;

endmodule

// ===== sv/ipv6tf_checker.sv =====
`timescale 1ns / 1ps
// Port-level checker for the IPv6 canonical text formatter, with its bind.
// Depends only on the ports of ipv6_canonical_text_formatter_unit.
module ipv6tf_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        start,
    input logic        busy,
    input logic        o_strobe,
    input logic [6:0]  o_text_char,
    input logic        o_last_char
);

    // An accepted transaction makes the block busy at the next edge.
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (start && !busy) |=> busy)
        else $error("busy did not rise after an accepted transaction");

    // Characters before the final one appear only while a transaction is in progress.
    a_strobe_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && !o_last_char) |-> busy)
        else $error("character strobe while idle");

    // The final character is shown in the first idle cycle.
    a_last_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_strobe && o_last_char) |-> !busy)
        else $error("block still busy with the final character");

    // Every character is a digit, a lowercase hex letter or a colon.
    a_char_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_strobe |-> (((o_text_char >= 7'h30) && (o_text_char <= 7'h3A)) ||
                      ((o_text_char >= 7'h61) && (o_text_char <= 7'h66))))
        else $error("character outside the canonical set");

endmodule

bind ipv6_canonical_text_formatter_unit ipv6tf_checker u_ipv6tf_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .start       (start),
    .busy        (busy),
    .o_strobe    (o_strobe),
    .o_text_char (o_text_char),
    .o_last_char (o_last_char)
);

// ===== sim/testbench.sv =====
`timescale 1ns / 1ps
// Testbench for ipv6_canonical_text_formatter_unit: drives addresses through the
// start/busy handshake and checks every emitted character against a local
// formatter. Depends on ipv6tf_pkg and the formatter RTL.
module testbench;

    localparam int CYCLE_LIMIT = 150000;
    localparam int RANDOM_ITEMS = 450;
    localparam int TAIL_CYCLES = 64;

    // One pending address transaction; drain holds it back until all text is out.
    typedef struct {
        logic [63:0] hi;
        logic [63:0] lo;
        bit          drain;
    } t_addr_item;

    // One expected character of the text stream.
    typedef struct {
        logic [6:0] code;
        logic       last;
    } t_text_char;

    logic        i_clk = 1'b0;
    logic        i_rst_n = 1'b0;
    logic        start = 1'b0;
    logic [63:0] i_addr_high = '0;
    logic [63:0] i_addr_low = '0;
    logic        busy;
    logic        o_strobe;
    logic [6:0]  o_text_char;
    logic        o_last_char;

    t_addr_item addr_pending[$];
    t_text_char text_expected[$];
    logic [6:0] text_line[$];
    int         total_items = 0;
    int         accepted_count = 0;
    int         launched_count = 0;
    int         mismatch_count = 0;
    int         cycle_count = 0;

    ipv6_canonical_text_formatter_unit u_top (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .start       (start),
        .busy        (busy),
        .i_addr_high (i_addr_high),
        .i_addr_low  (i_addr_low),
        .o_strobe    (o_strobe),
        .o_text_char (o_text_char),
        .o_last_char (o_last_char)
    );

    // Free-running clock.
    initial begin
        forever #10 i_clk = ~i_clk;
    end

    // Prints one line per mismatch and counts every one.
    task automatic report_mismatch(input string msg);
        $display("[%0t] mismatch: %s", $realtime, msg);
        mismatch_count++;
    endtask

    // Appends one character to the text line being built.
    function automatic void append_char(input logic [6:0] c);
        text_line.insert(text_line.size(), c);
    endfunction

    // Appends one group in hex without leading zeros; a zero group gives "0".
    function automatic void put_hex_group(input logic [15:0] grp);
        bit seen;
        logic [3:0] nib;
        seen = 1'b0;
        for (int sh = 12; sh >= 0; sh -= 4) begin
            nib = grp[sh +: 4];
            if (nib != 4'h0 || seen || sh == 0) begin
                append_char(ipv6tf_pkg::C_HEX_CHARS[nib]);
                seen = 1'b1;
            end
        end
    endfunction

    // Builds the canonical text of one address and queues it as expected characters.
    function automatic void format_canonical(input logic [63:0] hi, input logic [63:0] lo);
        logic [15:0] grp [ipv6tf_pkg::GROUP_COUNT];
        int first_zero;
        int zero_len;
        int run;
        int after;
        t_text_char ch;
        first_zero = 0;
        zero_len = 0;
        run = 0;
        text_line.delete();
        for (int i = 0; i < 4; i++) begin
            grp[i] = hi[63 - 16 * i -: 16];
            grp[i + 4] = lo[63 - 16 * i -: 16];
        end

        // Find the longest zero run; a strictly longer run is needed to replace one.
        for (int i = 0; i < ipv6tf_pkg::GROUP_COUNT; i++) begin
            if (grp[i] == 16'h0) begin
                run++;
                if (run > zero_len) begin
                    zero_len = run;
                    first_zero = i + 1 - run;
                end
            end else begin
                run = 0;
            end
        end

        if (zero_len < 2) begin
            for (int i = 0; i < ipv6tf_pkg::GROUP_COUNT; i++) begin
                if (i > 0) append_char(ipv6tf_pkg::C_ASCII_COLON);
                put_hex_group(grp[i]);
            end
        end else begin
            after = first_zero + zero_len;
            for (int i = 0; i < first_zero; i++) begin
                if (i > 0) append_char(ipv6tf_pkg::C_ASCII_COLON);
                put_hex_group(grp[i]);
            end
            append_char(ipv6tf_pkg::C_ASCII_COLON);
            append_char(ipv6tf_pkg::C_ASCII_COLON);
            for (int i = after; i < ipv6tf_pkg::GROUP_COUNT; i++) begin
                if (i > after) append_char(ipv6tf_pkg::C_ASCII_COLON);
                put_hex_group(grp[i]);
            end
        end

        foreach (text_line[i]) begin
            ch.code = text_line[i];
            ch.last = (i == text_line.size() - 1);
            text_expected.insert(text_expected.size(), ch);
        end
    endfunction

    function automatic void add_item(input logic [63:0] hi, input logic [63:0] lo,
                                     input bit drain);
        t_addr_item it;
        it.hi = hi;
        it.lo = lo;
        it.drain = drain;
        addr_pending.insert(addr_pending.size(), it);
        total_items++;
    endfunction

    // Random address built group by group, with a per-address density of zero groups.
    function automatic void add_random_item(input bit drain);
        logic [15:0] grp [ipv6tf_pkg::GROUP_COUNT];
        logic [63:0] hi;
        logic [63:0] lo;
        int zero_pct;
        if ($urandom_range(9) == 0) begin
            add_item({$urandom, $urandom}, {$urandom, $urandom}, drain);
        end else begin
            case ($urandom_range(4))
                0: zero_pct = 0;
                1: zero_pct = 20;
                2: zero_pct = 40;
                3: zero_pct = 60;
                default: zero_pct = 90;
            endcase
            for (int g = 0; g < ipv6tf_pkg::GROUP_COUNT; g++) begin
                if ($urandom_range(99) < zero_pct) begin
                    grp[g] = 16'h0;
                end else begin
                    case ($urandom_range(3))
                        0: grp[g] = 16'($urandom_range(1, 15));
                        1: grp[g] = 16'($urandom_range(16, 255));
                        2: grp[g] = 16'($urandom_range(256, 4095));
                        default: grp[g] = 16'($urandom);
                    endcase
                end
            end
            for (int i = 0; i < 4; i++) begin
                hi[63 - 16 * i -: 16] = grp[i];
                lo[63 - 16 * i -: 16] = grp[i + 4];
            end
            add_item(hi, lo, drain);
        end
    endfunction

    // Driver: counts the accepted transaction and presents the next address.
    always @(posedge i_clk) begin : drive_proc
        bit taken;
        bit launch;
        bit idle_ok;
        t_addr_item it;
        if (!i_rst_n) begin
            start <= 1'b0;
        end else begin
            taken = start && !busy;
            if (taken) begin
                format_canonical(i_addr_high, i_addr_low);
                accepted_count++;
            end
            if (taken || !start) begin
                launch = 1'b0;
                // No idling during one long stretch in the middle of the run.
                idle_ok = (launched_count < 180 || launched_count >= 300);
                if (addr_pending.size() > 0 && !(idle_ok && $urandom_range(99) < 28)) begin
                    if (!addr_pending[0].drain || text_expected.size() == 0) begin
                        launch = 1'b1;
                    end
                end
                if (launch) begin
                    it = addr_pending.pop_front();
                    launched_count++;
                    start <= 1'b1;
                    i_addr_high <= it.hi;
                    i_addr_low <= it.lo;
                end else begin
                    start <= 1'b0;
                end
            end
        end
    end

    // Monitor: every strobed character must match the oldest expected one.
    always @(posedge i_clk) begin : watch_proc
        t_text_char want;
        if (i_rst_n && o_strobe) begin
            if (text_expected.size() == 0) begin
                report_mismatch($sformatf("character 0x%0h with none expected", o_text_char));
            end else begin
                want = text_expected.pop_front();
                if (o_text_char !== want.code) begin
                    report_mismatch($sformatf("text_char got 0x%0h want 0x%0h",
                                              o_text_char, want.code));
                end
                if (o_last_char !== want.last) begin
                    report_mismatch($sformatf("last_char got %b want %b",
                                              o_last_char, want.last));
                end
            end
        end
    end

    // Run limit.
    always @(posedge i_clk) begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // Stimulus, reset and end of run.
    initial begin
        // Directed part: extremes and the zero-run corner cases.
        add_item(64'h0, 64'h0, 1'b0);
        add_item('1, '1, 1'b0);
        add_item(64'h0001_0000_0001_0001, 64'h0001_0001_0001_0001, 1'b0);
        add_item(64'h0000_0000_0001_0001, 64'h0001_0001_0001_0001, 1'b0);
        add_item(64'h0001_0001_0001_0001, 64'h0001_0001_0000_0000, 1'b0);
        add_item(64'h0001_0000_0000_0001, 64'h0000_0000_0001_0001, 1'b0);
        add_item(64'h0001_0000_0000_0001, 64'h0000_0000_0000_0001, 1'b0);
        add_item(64'h0000_0001_0000_0001, 64'h0000_0001_0000_0001, 1'b0);
        add_item(64'h0000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0);
        add_item(64'h0001_0000_0000_0000, 64'h0000_0000_0000_0000, 1'b0);
        add_item(64'h0000_0000_0000_abcd, 64'h0000_0000_0000_0000, 1'b0);
        add_item(64'h0123_4567_89ab_cdef, 64'hfedc_ba98_7654_3210, 1'b0);
        add_item(64'h000f_00f0_0f00_f000, 64'h0010_0100_1000_0001, 1'b0);
        add_item(64'h0, '1, 1'b0);
        add_item('1, 64'h0, 1'b0);
        add_item(64'h8000_0000_0000_0000, 64'h0000_0000_0000_0001, 1'b0);
        add_item(64'h2001_0db8_0000_0000, 64'h0000_ff00_0042_8329, 1'b0);
        add_item(64'h0000_0000_0000_0001, 64'h0000_0000_0000_0000, 1'b0);
        add_item(64'h1234_0000_5678_0000, 64'h9abc_0000_def0_0000, 1'b0);
        add_item(64'h0000_ffff_ffff_ffff, 64'hffff_ffff_ffff_0000, 1'b0);

        // Random part; a few items wait for the text stream to run dry first.
        for (int n = 0; n < RANDOM_ITEMS; n++) begin
            add_random_item(n == 0 || n == 150 || n == 320);
        end

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        while (accepted_count < total_items || text_expected.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (TAIL_CYCLES) @(posedge i_clk);

        if (mismatch_count == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule

// ===== filelist.f =====
sv/ipv6tf_pkg.sv
sv/ipv6tf_run_scan.sv
sv/ipv6_canonical_text_formatter_unit.sv
sv/ipv6tf_checker.sv
sim/testbench.sv
